>>> design/mtcv_pkg.sv
// Shared types, constants and the pitch table for the MIDI to CV voice allocator.
// No dependencies.
`timescale 1ns / 1ps

package mtcv_pkg;

  localparam int unsigned VOICE_COUNT      = 4;
  localparam int unsigned PITCH_TABLE_SIZE = 49;
  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam logic [7:0] NOTE_BASE       = 8'd60;
  localparam logic [7:0] EV_NOTE_ON      = 8'h09;
  localparam logic [7:0] EV_NOTE_OFF     = 8'h08;
  localparam logic [3:0] POLY_CHANNEL    = 4'd4;
  localparam logic [2:0] VEL_SHIFT_RESET = 3'd1;

  typedef struct packed {
    logic       write_valid;
    logic [1:0] dac_chip;
    logic       dac_side;
    logic [7:0] dac_value;
    logic [3:0] gate_levels;
    logic       poly_mode;
    logic       last;
  } result_t;

  function automatic logic [7:0] pitch_rom(input logic [6:0] idx);
    logic [7:0] val;
    unique case (idx)
      7'd0:  val = 8'd0;    7'd1:  val = 8'd4;    7'd2:  val = 8'd9;
      7'd3:  val = 8'd13;   7'd4:  val = 8'd17;   7'd5:  val = 8'd21;
      7'd6:  val = 8'd26;   7'd7:  val = 8'd30;   7'd8:  val = 8'd34;
      7'd9:  val = 8'd38;   7'd10: val = 8'd43;   7'd11: val = 8'd47;
      7'd12: val = 8'd51;   7'd13: val = 8'd55;   7'd14: val = 8'd60;
      7'd15: val = 8'd64;   7'd16: val = 8'd68;   7'd17: val = 8'd73;
      7'd18: val = 8'd77;   7'd19: val = 8'd81;   7'd20: val = 8'd85;
      7'd21: val = 8'd90;   7'd22: val = 8'd94;   7'd23: val = 8'd98;
      7'd24: val = 8'd102;  7'd25: val = 8'd107;  7'd26: val = 8'd111;
      7'd27: val = 8'd115;  7'd28: val = 8'd119;  7'd29: val = 8'd124;
      7'd30: val = 8'd128;  7'd31: val = 8'd132;  7'd32: val = 8'd137;
      7'd33: val = 8'd141;  7'd34: val = 8'd145;  7'd35: val = 8'd149;
      7'd36: val = 8'd154;  7'd37: val = 8'd158;  7'd38: val = 8'd162;
      7'd39: val = 8'd166;  7'd40: val = 8'd171;  7'd41: val = 8'd175;
      7'd42: val = 8'd179;  7'd43: val = 8'd183;  7'd44: val = 8'd188;
      7'd45: val = 8'd192;  7'd46: val = 8'd196;  7'd47: val = 8'd201;
      7'd48: val = 8'd205;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

>>> design/mtcv_if.sv
// Valid/ready channel interfaces for MIDI event packets and DAC write results.
// Depends on nothing.
`timescale 1ns / 1ps

interface mtcv_event_if;
  logic       valid;
  logic       ready;
  logic [7:0] event_code;
  logic [7:0] status_byte;
  logic [7:0] note_number;
  logic [7:0] velocity;

  modport source (output valid, event_code, status_byte, note_number, velocity,
                  input ready);
  modport sink   (input valid, event_code, status_byte, note_number, velocity,
                  output ready);
endinterface

interface mtcv_result_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [1:0] dac_chip;
  logic       dac_side;
  logic [7:0] dac_value;
  logic [3:0] gate_levels;
  logic       poly_mode;
  logic       last;

  modport source (output valid, write_valid, dac_chip, dac_side, dac_value, gate_levels,
                  poly_mode, last, input ready);
  modport sink   (input valid, write_valid, dac_chip, dac_side, dac_value, gate_levels,
                  poly_mode, last, output ready);
endinterface

>>> design/mtcv_result_queue.sv
// Result queue: takes one or two results per cycle, hands out one per transfer.
// Depends on mtcv_pkg and mtcv_result_if.
`timescale 1ns / 1ps

module mtcv_result_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              push_two_i,
  input  mtcv_pkg::result_t entry0_i,
  input  mtcv_pkg::result_t entry1_i,
  output logic              space_o,
  mtcv_result_if.source     res_o
);

  localparam int unsigned CntW = $clog2(mtcv_pkg::QUEUE_DEPTH + 1);

  mtcv_pkg::result_t entry_q [mtcv_pkg::QUEUE_DEPTH];
  mtcv_pkg::result_t entry_d [mtcv_pkg::QUEUE_DEPTH];
  mtcv_pkg::result_t shifted [mtcv_pkg::QUEUE_DEPTH];
  logic [CntW-1:0]   count_q, count_d, base;
  logic              pop;

  assign pop     = res_o.valid && res_o.ready;
  assign space_o = count_q <= CntW'(mtcv_pkg::QUEUE_DEPTH - 2);
  assign base    = count_q - CntW'(pop);

  always_comb begin
    for (int i = 0; i < mtcv_pkg::QUEUE_DEPTH - 1; i++) begin
      shifted[i] = pop ? entry_q[i + 1] : entry_q[i];
    end
    shifted[mtcv_pkg::QUEUE_DEPTH - 1] = entry_q[mtcv_pkg::QUEUE_DEPTH - 1];
    for (int i = 0; i < mtcv_pkg::QUEUE_DEPTH; i++) begin
      entry_d[i] = shifted[i];
      if (push_i && base == CntW'(i)) begin
        entry_d[i] = entry0_i;
      end
      if (push_i && push_two_i && (base + CntW'(1)) == CntW'(i)) begin
        entry_d[i] = entry1_i;
      end
    end
    count_d = count_q - CntW'(pop) + CntW'(push_i) + CntW'(push_i && push_two_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign res_o.valid       = count_q != '0;
  assign res_o.write_valid = entry_q[0].write_valid;
  assign res_o.dac_chip    = entry_q[0].dac_chip;
  assign res_o.dac_side    = entry_q[0].dac_side;
  assign res_o.dac_value   = entry_q[0].dac_value;
  assign res_o.gate_levels = entry_q[0].gate_levels;
  assign res_o.poly_mode   = entry_q[0].poly_mode;
  assign res_o.last        = entry_q[0].last;

endmodule

>>> design/midi_to_cv_voice_allocator.sv
// Four-voice MIDI to CV voice allocator, top level.
// Depends on mtcv_pkg, mtcv_if and mtcv_result_queue.
`timescale 1ns / 1ps

// Usage:
//   evt_i carries one USB-MIDI event packet per transfer; res_o carries DAC
//   writes and gate/mode status, one result per transfer, with last set on the
//   final result of each packet. A note-on that is played gives a pitch write
//   (when the note is in the table) and a velocity write; any other packet
//   gives one result with write_valid low.
//   cfg_we_i/cfg_wdata_i load velocity_shift; write it while the block is idle.
//   Voice state updates in the cycle a packet transfers; its results are
//   registered in the result queue before they appear on res_o.
//   A packet can transfer every cycle while the four-entry result queue has
//   room for two results; sustained rate is one result per cycle at the
//   output while the receiver is ready, so a note-on gives two results there.
//   When the receiver stalls, results hold in the queue and evt_i.ready drops
//   once fewer than two entries are free.
//   Reset: four-channel mode, all voices free, gates low, velocity_shift 1.
module midi_to_cv_voice_allocator #(
  parameter int unsigned PITCH_TABLE_SIZE = mtcv_pkg::PITCH_TABLE_SIZE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_wdata_i,
  mtcv_event_if.sink    evt_i,
  mtcv_result_if.source res_o
);

  localparam int unsigned VoiceW = $clog2(mtcv_pkg::VOICE_COUNT);

  logic [2:0]                      vel_shift_q;
  logic                            mode_q, mode_d;
  logic [mtcv_pkg::VOICE_COUNT-1:0] busy_q, busy_d, gate_q, gate_d;
  logic [7:0]                      note_q [mtcv_pkg::VOICE_COUNT];

  logic              accept, space;
  logic [3:0]        ch;
  logic [7:0]        idx, vel_val, pitch_val;
  logic              is_on, is_off, in_range;
  logic              free_found, match_found, play, note_we;
  logic [VoiceW-1:0] free_v, match_v, play_v;
  mtcv_pkg::result_t res0, res1, pitch_res, vel_res;
  logic              push_two;

  assign accept   = evt_i.valid && evt_i.ready;
  assign evt_i.ready = space;
  assign ch       = evt_i.status_byte[3:0];
  assign idx      = evt_i.note_number - mtcv_pkg::NOTE_BASE;
  assign is_on    = evt_i.event_code == mtcv_pkg::EV_NOTE_ON;
  assign is_off   = evt_i.event_code == mtcv_pkg::EV_NOTE_OFF;
  assign in_range = {1'b0, idx} < 9'(PITCH_TABLE_SIZE);
  assign vel_val  = evt_i.velocity << vel_shift_q;
  assign pitch_val = mtcv_pkg::pitch_rom(idx[6:0]);

  always_comb begin
    free_found  = 1'b0;
    free_v      = '0;
    match_found = 1'b0;
    match_v     = '0;
    for (int i = mtcv_pkg::VOICE_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_v     = VoiceW'(i);
      end
      if (busy_q[i] && note_q[i] == idx) begin
        match_found = 1'b1;
        match_v     = VoiceW'(i);
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    busy_d  = busy_q;
    gate_d  = gate_q;
    play    = 1'b0;
    play_v  = '0;
    note_we = 1'b0;
    if (!mode_q) begin
      if (ch == mtcv_pkg::POLY_CHANNEL) begin
        mode_d = 1'b1;
      end else if (ch < mtcv_pkg::POLY_CHANNEL) begin
        if (is_on) begin
          play   = 1'b1;
          play_v = ch[VoiceW-1:0];
        end else if (is_off) begin
          gate_d[ch[VoiceW-1:0]] = 1'b0;
        end
      end
    end else begin
      if (ch < mtcv_pkg::POLY_CHANNEL) begin
        busy_d = '0;
        gate_d = '0;
        mode_d = 1'b0;
      end else if (ch == mtcv_pkg::POLY_CHANNEL) begin
        if (is_on && free_found) begin
          play           = 1'b1;
          play_v         = free_v;
          note_we        = 1'b1;
          busy_d[free_v] = 1'b1;
        end else if (is_off && match_found) begin
          busy_d[match_v] = 1'b0;
          gate_d[match_v] = 1'b0;
        end
      end
    end
    if (play) begin
      gate_d[play_v] = 1'b1;
    end
  end

  always_comb begin
    pitch_res             = '0;
    pitch_res.write_valid = 1'b1;
    pitch_res.dac_chip    = {1'b0, play_v[1]};
    pitch_res.dac_side    = play_v[0];
    pitch_res.dac_value   = pitch_val;
    pitch_res.gate_levels = gate_q;
    pitch_res.poly_mode   = mode_q;

    vel_res             = '0;
    vel_res.write_valid = 1'b1;
    vel_res.dac_chip    = {1'b1, play_v[1]};
    vel_res.dac_side    = play_v[0];
    vel_res.dac_value   = vel_val;
    vel_res.gate_levels = gate_d;
    vel_res.poly_mode   = mode_d;
    vel_res.last        = 1'b1;

    res1     = vel_res;
    push_two = 1'b0;
    if (play && in_range) begin
      res0     = pitch_res;
      push_two = 1'b1;
    end else if (play) begin
      res0 = vel_res;
    end else begin
      res0             = '0;
      res0.gate_levels = gate_d;
      res0.poly_mode   = mode_d;
      res0.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_shift_q <= mtcv_pkg::VEL_SHIFT_RESET;
      mode_q      <= 1'b0;
      busy_q      <= '0;
      gate_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        vel_shift_q <= cfg_wdata_i;
      end
      if (accept) begin
        mode_q <= mode_d;
        busy_q <= busy_d;
        gate_q <= gate_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && note_we) begin
      note_q[play_v] <= idx;
    end
  end

  mtcv_result_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_two_i (push_two),
    .entry0_i   (res0),
    .entry1_i   (res1),
    .space_o    (space),
    .res_o      (res_o)
  );

endmodule

>>> design/mtcv_checker.sv
// Port-level checks for the MIDI to CV voice allocator, bound to the top level.
// Depends on midi_to_cv_voice_allocator.
`timescale 1ns / 1ps

module mtcv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       write_valid_i,
  input logic [1:0] dac_chip_i,
  input logic [7:0] dac_value_i,
  input logic       last_i
);

  a_nowrite_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !write_valid_i |-> last_i && dac_chip_i == 2'd0 && dac_value_i == 8'd0)
    else $error("result without write is not a final zero result");

  a_vel_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && write_valid_i && dac_chip_i[1] |-> last_i)
    else $error("velocity write is not the final result");

  a_pitch_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && write_valid_i && !dac_chip_i[1] |-> !last_i)
    else $error("pitch write marked final");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(dac_value_i) && $stable(last_i))
    else $error("stalled result changed");

endmodule

bind midi_to_cv_voice_allocator mtcv_checker u_mtcv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .write_valid_i (res_o.write_valid),
  .dac_chip_i    (res_o.dac_chip),
  .dac_value_i   (res_o.dac_value),
  .last_i        (res_o.last)
);

>>> tb/tb_midi_to_cv_voice_allocator.sv
// Self-checking testbench for the four-voice MIDI to CV voice allocator.
// Drives MIDI packets, predicts DAC writes, gates and mode, checks every result.
// Depends on mtcv_pkg, mtcv_if and midi_to_cv_voice_allocator.
`timescale 1ns / 1ps

module tb_midi_to_cv_voice_allocator;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] status;
    logic [7:0] note;
    logic [7:0] vel;
  } midi_pkt_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;

  mtcv_event_if  evt_bus ();
  mtcv_result_if res_bus ();

  midi_to_cv_voice_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt_bus),
    .res_o       (res_bus)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0] pitch_cv_tab [0:48] = '{
    8'd0,   8'd4,   8'd9,   8'd13,  8'd17,  8'd21,  8'd26,  8'd30,  8'd34,  8'd38,
    8'd43,  8'd47,  8'd51,  8'd55,  8'd60,  8'd64,  8'd68,  8'd73,  8'd77,  8'd81,
    8'd85,  8'd90,  8'd94,  8'd98,  8'd102, 8'd107, 8'd111, 8'd115, 8'd119, 8'd124,
    8'd128, 8'd132, 8'd137, 8'd141, 8'd145, 8'd149, 8'd154, 8'd158, 8'd162, 8'd166,
    8'd171, 8'd175, 8'd179, 8'd183, 8'd188, 8'd192, 8'd196, 8'd201, 8'd205
  };

  // Allocator shadow state
  logic       poly_q;
  logic [3:0] busy_q;
  logic [7:0] held_note_q [4];
  logic [3:0] gates_q;
  logic [2:0] vel_shift_q;

  midi_pkt_t          midi_pending_q [$];
  mtcv_pkg::result_t  expected_dac_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;

  task automatic log_error(input string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endtask

  task automatic play_voice(input logic [1:0] v, input logic [7:0] idx, input logic [7:0] vel);
    logic [1:0]  chip;
    logic [15:0] scaled;
    chip = {1'b0, v[1]};
    if (idx < mtcv_pkg::PITCH_TABLE_SIZE) begin
      expected_dac_q.push_back('{write_valid: 1'b1, dac_chip: chip, dac_side: v[0],
                                 dac_value: pitch_cv_tab[idx], gate_levels: gates_q,
                                 poly_mode: poly_q, last: 1'b0});
    end
    gates_q[v] = 1'b1;
    scaled = {8'd0, vel} << vel_shift_q;
    expected_dac_q.push_back('{write_valid: 1'b1, dac_chip: chip + 2'd2, dac_side: v[0],
                               dac_value: scaled[7:0], gate_levels: gates_q,
                               poly_mode: poly_q, last: 1'b1});
  endtask

  task automatic predict_voice_writes(input midi_pkt_t p);
    logic [3:0] ch;
    logic [7:0] idx;
    bit         played;
    bit         freed;
    ch     = p.status[3:0];
    idx    = p.note - mtcv_pkg::NOTE_BASE;
    played = 1'b0;
    freed  = 1'b0;
    if (!poly_q) begin
      if (ch == mtcv_pkg::POLY_CHANNEL) begin
        poly_q = 1'b1;
      end else if (ch < mtcv_pkg::POLY_CHANNEL) begin
        if (p.code == mtcv_pkg::EV_NOTE_ON) begin
          play_voice(ch[1:0], idx, p.vel);
          played = 1'b1;
        end else if (p.code == mtcv_pkg::EV_NOTE_OFF) begin
          gates_q[ch[1:0]] = 1'b0;
        end
      end
    end else if (ch < mtcv_pkg::POLY_CHANNEL) begin
      busy_q  = '0;
      gates_q = '0;
      poly_q  = 1'b0;
    end else if (ch == mtcv_pkg::POLY_CHANNEL) begin
      if (p.code == mtcv_pkg::EV_NOTE_ON) begin
        for (int i = 0; i < 4; i++) begin
          if (!played && !busy_q[i]) begin
            busy_q[i]      = 1'b1;
            held_note_q[i] = idx;
            play_voice(2'(i), idx, p.vel);
            played = 1'b1;
          end
        end
      end else if (p.code == mtcv_pkg::EV_NOTE_OFF) begin
        for (int i = 0; i < 4; i++) begin
          if (!freed && busy_q[i] && held_note_q[i] == idx) begin
            gates_q[i] = 1'b0;
            busy_q[i]  = 1'b0;
            freed      = 1'b1;
          end
        end
      end
    end
    if (!played) begin
      expected_dac_q.push_back('{write_valid: 1'b0, dac_chip: 2'd0, dac_side: 1'b0,
                                 dac_value: 8'd0, gate_levels: gates_q,
                                 poly_mode: poly_q, last: 1'b1});
    end
  endtask

  // Packet driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_bus.valid       <= 1'b0;
      evt_bus.event_code  <= '0;
      evt_bus.status_byte <= '0;
      evt_bus.note_number <= '0;
      evt_bus.velocity    <= '0;
    end else begin : drive_blk
      bit moved;
      moved = evt_bus.valid && evt_bus.ready;
      if (moved) predict_voice_writes(midi_pending_q.pop_front());
      if (!evt_bus.valid || moved) begin
        if (midi_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          evt_bus.valid       <= 1'b1;
          evt_bus.event_code  <= midi_pending_q[0].code;
          evt_bus.status_byte <= midi_pending_q[0].status;
          evt_bus.note_number <= midi_pending_q[0].note;
          evt_bus.velocity    <= midi_pending_q[0].vel;
        end else begin
          evt_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin : watch_blk
      mtcv_pkg::result_t got;
      mtcv_pkg::result_t want;
      if (res_bus.valid && res_bus.ready) begin
        got = '{write_valid: res_bus.write_valid, dac_chip: res_bus.dac_chip,
                dac_side: res_bus.dac_side, dac_value: res_bus.dac_value,
                gate_levels: res_bus.gate_levels, poly_mode: res_bus.poly_mode,
                last: res_bus.last};
        if (expected_dac_q.size() == 0) begin
          log_error($sformatf("unexpected result %p", got));
        end else begin
          want = expected_dac_q.pop_front();
          if (got !== want) log_error($sformatf("mismatch: expected %p, got %p", want, got));
        end
      end
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_pkt(input logic [7:0] code, input logic [7:0] status,
                         input logic [7:0] note, input logic [7:0] vel);
    midi_pending_q.push_back('{code: code, status: status, note: note, vel: vel});
  endtask

  task automatic set_velocity_shift(input logic [2:0] shift);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= shift;
    vel_shift_q = shift;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (midi_pending_q.size() != 0 || evt_bus.valid || expected_dac_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Bursts of poly, four-channel or other-channel traffic around a small set of held notes
  task automatic queue_random_traffic(input int target);
    int         played_cnt;
    int         kind;
    int         len;
    int         r;
    logic [3:0] ch;
    logic [7:0] code;
    logic [7:0] note;
    logic [7:0] held [6];
    played_cnt = 0;
    foreach (held[i]) held[i] = 8'($urandom_range(50, 118));
    while (played_cnt < target) begin
      kind = $urandom_range(99);
      len  = (kind < 45) ? $urandom_range(3, 16) :
             (kind < 80) ? $urandom_range(1, 8) : $urandom_range(1, 3);
      repeat (len) begin
        r    = $urandom_range(99);
        code = (r < 50) ? mtcv_pkg::EV_NOTE_ON :
               (r < 85) ? mtcv_pkg::EV_NOTE_OFF : 8'($urandom);
        if (kind < 45)      ch = mtcv_pkg::POLY_CHANNEL;
        else if (kind < 80) ch = 4'($urandom_range(0, 3));
        else if (kind < 92) ch = 4'($urandom_range(5, 15));
        else                ch = 4'($urandom);
        r    = $urandom_range(99);
        note = (r < 50) ? held[$urandom_range(5)] :
               (r < 80) ? 8'($urandom_range(60, 108)) : 8'($urandom);
        add_pkt(code, {4'($urandom), ch}, note, 8'($urandom));
        if ((code == mtcv_pkg::EV_NOTE_ON || code == mtcv_pkg::EV_NOTE_OFF) &&
            ch <= mtcv_pkg::POLY_CHANNEL) played_cnt++;
      end
    end
  endtask

  initial begin
    logic [2:0] shifts [6];
    shifts = '{3'd0, 3'd7, 3'd3, 3'd6, 3'd2, 3'd5};
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    evt_bus.valid       = 1'b0;
    evt_bus.event_code  = '0;
    evt_bus.status_byte = '0;
    evt_bus.note_number = '0;
    evt_bus.velocity    = '0;
    res_bus.ready       = 1'b0;
    poly_q              = 1'b0;
    busy_q              = '0;
    gates_q             = '0;
    vel_shift_q         = mtcv_pkg::VEL_SHIFT_RESET;
    error_count         = 0;
    send_idle_pct       = 37;
    recv_idle_pct       = 55;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Four-channel mode: pitch range edges, out-of-range notes, note-off, ignored packets
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h90, 8'd60,  8'd0);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h91, 8'd108, 8'd255);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h92, 8'd59,  8'd128);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h93, 8'd109, 8'd1);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'hF3, 8'd0,   8'd127);
    add_pkt(mtcv_pkg::EV_NOTE_OFF, 8'h81, 8'd108, 8'd64);
    add_pkt(8'h0A,                 8'hA0, 8'd70,  8'd70);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h9F, 8'd72,  8'd90);
    add_pkt(mtcv_pkg::EV_NOTE_OFF, 8'h82, 8'd255, 8'd0);
    // Enter poly mode, fill all voices, overflow, matched and unmatched note-off
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd72,  8'd100);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd60,  8'd255);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd255, 8'd7);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd108, 8'd64);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd61,  8'd33);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd62,  8'd200);
    add_pkt(mtcv_pkg::EV_NOTE_OFF, 8'h84, 8'd255, 8'd0);
    add_pkt(mtcv_pkg::EV_NOTE_OFF, 8'h84, 8'd99,  8'd0);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd84,  8'd15);
    add_pkt(8'h0F,                 8'h94, 8'd84,  8'd15);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h9A, 8'd70,  8'd70);
    // Leave poly mode, then duplicate notes in poly mode
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h02, 8'd66,  8'd66);
    add_pkt(mtcv_pkg::EV_NOTE_OFF, 8'h84, 8'd66,  8'd0);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd65,  8'd11);
    add_pkt(mtcv_pkg::EV_NOTE_ON,  8'h94, 8'd65,  8'd22);
    add_pkt(mtcv_pkg::EV_NOTE_OFF, 8'h84, 8'd65,  8'd0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 55 : 0;
      recv_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 37 : 0;
      set_velocity_shift(shifts[ph]);
      queue_random_traffic(150);
      wait_idle();
    end

    if (expected_dac_q.size() != 0)
      log_error($sformatf("%0d expected results never arrived", expected_dac_q.size()));
    if (error_count == 0) begin
      $display("tb_midi_to_cv_voice_allocator: done, clean");
    end else begin
      $display("tb_midi_to_cv_voice_allocator: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_midi_to_cv_voice_allocator: done, errors");
    $finish;
  end

endmodule

>>> midi_to_cv_voice_allocator.f
design/mtcv_pkg.sv
design/mtcv_if.sv
design/mtcv_result_queue.sv
design/midi_to_cv_voice_allocator.sv
design/mtcv_checker.sv
tb/tb_midi_to_cv_voice_allocator.sv
